>>> hdl/smkd_pkg.sv
// Shared types, marker constants and kind decode functions for the save-memory kind detector.
`default_nettype none
package smkd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 18;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_FL64   = 3'd1,
    KIND_FL128  = 3'd2,
    KIND_SRAM   = 3'd3,
    KIND_EEPROM = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAGE_IDLE = 2'd0,
    STAGE_EEPR = 2'd1,
    STAGE_FLAS = 2'd2,
    STAGE_SRAM = 2'd3
  } stage_e;

  // Marker words as they appear with the first byte in bits 7..0.
  localparam logic [WordW-1:0] MarkEepr = 32'h5250_4545;
  localparam logic [WordW-1:0] MarkFlas = 32'h5341_4c46;
  localparam logic [WordW-1:0] MarkSram = 32'h4d41_5253;
  localparam logic [WordW-1:0] TailOmV  = 32'h565f_4d4f;
  localparam logic [23:0]      TailHV   = 24'h56_5f48;
  localparam logic [WordW-1:0] TailH512 = 32'h3231_3548;
  localparam logic [WordW-1:0] TailH1m  = 32'h5f4d_3148;
  localparam logic [15:0]      TailUV   = 16'h565f;
  localparam logic [WordW-1:0] TailUFV  = 32'h565f_465f;

  function automatic logic [BytesW-1:0] kind_bytes(input logic [2:0] kind);
    logic [BytesW-1:0] bytes;
    case (kind)
      KIND_FL64:   bytes = 18'd65536;
      KIND_FL128:  bytes = 18'd131072;
      KIND_SRAM:   bytes = 18'd65536;
      KIND_EEPROM: bytes = 18'd8192;
      default:     bytes = '0;
    endcase
    return bytes;
  endfunction

  function automatic logic kind_ones(input logic [2:0] kind);
    return (kind == KIND_FL64) || (kind == KIND_FL128) || (kind == KIND_SRAM);
  endfunction

endpackage
`default_nettype wire

>>> hdl/save_memory_kind_detector.sv
// An accepted beat is captured in the input register, then moves into the result register,
// where it is presented as a result beat (out_valid_o high) until the receiver takes it.
// Throughput: one beat per cycle; the input register and the result register form a
// two-stage pipeline that advances whenever the result register is empty or being taken.
// Reset: rst_ni is asynchronous and active low; it empties both stages and returns the
// match stage to idle and the detected kind to none.
`default_nettype none
module save_memory_kind_detector (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [smkd_pkg::WordW-1:0]  image_word_i,
  input  wire logic                        start_of_image_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       save_kind_o,
  output logic [smkd_pkg::BytesW-1:0]      save_bytes_o,
  output logic                             fill_with_ones_o
);

  // Input register stage. It captures each accepted beat so that the match
  // logic starts from a flop rather than from the input pins.
  logic                       in_valid_q;
  logic [smkd_pkg::WordW-1:0] word_q;
  logic                       start_q;

  // The pipeline moves forward when the result register is free or its beat
  // is being taken in this cycle.
  logic adv;
  logic out_valid;
  smkd_pkg::kind_e kind_next;

  assign adv        = !out_valid || out_ready_i;
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q  <= image_word_i;
      start_q <= start_of_image_i;
    end
  end

  // The detection state steps exactly when the registered beat moves into
  // the result register, so the state sees every beat once and in order.
  smkd_matcher u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv && in_valid_q),
    .word_i  (word_q),
    .start_i (start_q),
    .kind_o  (kind_next)
  );

  smkd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .load_valid_i (in_valid_q),
    .kind_i       (kind_next),
    .valid_o      (out_valid),
    .kind_o       (save_kind_o),
    .bytes_o      (save_bytes_o),
    .ones_o       (fill_with_ones_o)
  );

  assign out_valid_o = out_valid;

endmodule
`default_nettype wire

>>> hdl/smkd_matcher.sv
// Marker match stage and sticky detected kind, updated once per stepped word.
`default_nettype none
module smkd_matcher (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [smkd_pkg::WordW-1:0] word_i,
  input  wire logic                      start_i,
  output smkd_pkg::kind_e                kind_o
);

  smkd_pkg::stage_e stage_q, stage_d, stage_c;
  smkd_pkg::kind_e  kind_q, kind_d, kind_c;

  always_comb begin
    stage_c = start_i ? smkd_pkg::STAGE_IDLE : stage_q;
    kind_c  = start_i ? smkd_pkg::KIND_NONE  : kind_q;
    stage_d = stage_c;
    kind_d  = kind_c;
    // Once a kind is known, words are no longer examined.
    if (kind_c == smkd_pkg::KIND_NONE) begin
      case (stage_c)
        smkd_pkg::STAGE_IDLE: begin
          if (word_i == smkd_pkg::MarkEepr) begin
            stage_d = smkd_pkg::STAGE_EEPR;
          end else if (word_i == smkd_pkg::MarkFlas) begin
            stage_d = smkd_pkg::STAGE_FLAS;
          end else if (word_i == smkd_pkg::MarkSram) begin
            stage_d = smkd_pkg::STAGE_SRAM;
          end
        end
        smkd_pkg::STAGE_EEPR: begin
          if (word_i == smkd_pkg::TailOmV) kind_d = smkd_pkg::KIND_EEPROM;
          stage_d = smkd_pkg::STAGE_IDLE;
        end
        smkd_pkg::STAGE_FLAS: begin
          if ((word_i[23:0] == smkd_pkg::TailHV) || (word_i == smkd_pkg::TailH512)) begin
            kind_d = smkd_pkg::KIND_FL64;
          end else if (word_i == smkd_pkg::TailH1m) begin
            kind_d = smkd_pkg::KIND_FL128;
          end
          stage_d = smkd_pkg::STAGE_IDLE;
        end
        smkd_pkg::STAGE_SRAM: begin
          if ((word_i[15:0] == smkd_pkg::TailUV) || (word_i == smkd_pkg::TailUFV)) begin
            kind_d = smkd_pkg::KIND_SRAM;
          end
          stage_d = smkd_pkg::STAGE_IDLE;
        end
        default: stage_d = smkd_pkg::STAGE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= smkd_pkg::STAGE_IDLE;
      kind_q  <= smkd_pkg::KIND_NONE;
    end else if (step_i) begin
      stage_q <= stage_d;
      kind_q  <= kind_d;
    end
  end

  assign kind_o = kind_d;

endmodule
`default_nettype wire

>>> hdl/smkd_out_reg.sv
// Result register: holds the kind and its decoded save size and fill flag.
`default_nettype none
module smkd_out_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        load_valid_i,
  input  wire logic [2:0]                  kind_i,
  output logic                             valid_o,
  output logic [2:0]                       kind_o,
  output logic [smkd_pkg::BytesW-1:0]      bytes_o,
  output logic                             ones_o
);

  logic                        valid_q;
  logic [2:0]                  kind_q;
  logic [smkd_pkg::BytesW-1:0] bytes_q;
  logic                        ones_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && load_valid_i) begin
      kind_q  <= kind_i;
      bytes_q <= smkd_pkg::kind_bytes(kind_i);
      ones_q  <= smkd_pkg::kind_ones(kind_i);
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign bytes_o = bytes_q;
  assign ones_o  = ones_q;

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the save-memory kind detector: directed markers, random streams.
`timescale 1ns / 1ps

module tb;
  import smkd_pkg::*;

  // Shape of one result beat as the checker expects it.
  typedef struct packed {
    logic [2:0]        kind;
    logic [BytesW-1:0] bytes;
    logic              ones;
  } kind_report_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [WordW-1:0]  image_word_i;
  logic              start_of_image_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        save_kind_o;
  logic [BytesW-1:0] save_bytes_o;
  logic              fill_with_ones_o;

  // Our own copy of the detector state, advanced once per accepted input beat.
  stage_e tracked_stage;
  kind_e  tracked_kind;

  // Reports still owed by the block, oldest first.
  kind_report_t kind_reports_q[$];

  // Idling knobs shared by the sender task and the receiver process.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned hold_req;

  int unsigned words_sent;
  int unsigned reports_checked;
  int unsigned err_count;
  int unsigned kinds_seen [5];

  save_memory_kind_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .image_word_i     (image_word_i),
    .start_of_image_i (start_of_image_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .save_kind_o      (save_kind_o),
    .save_bytes_o     (save_bytes_o),
    .fill_with_ones_o (fill_with_ones_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges and a handshake never completes.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Save size for each kind; anything unknown reports an empty save.
  function automatic logic [BytesW-1:0] save_size_of(input kind_e kind);
    case (kind)
      KIND_FL64, KIND_SRAM: return 18'd65536;
      KIND_FL128:           return 18'd131072;
      KIND_EEPROM:          return 18'd8192;
      default:              return '0;
    endcase
  endfunction

  // Advances the tracked state by one image word and returns the report that follows.
  function automatic kind_report_t detect_kind(input logic [WordW-1:0] word,
                                               input logic start);
    kind_report_t rep;
    if (start) begin
      tracked_stage = STAGE_IDLE;
      tracked_kind  = KIND_NONE;
    end
    // Once a kind is known, words are ignored and the stage is left alone.
    if (tracked_kind == KIND_NONE) begin
      case (tracked_stage)
        STAGE_IDLE: begin
          if (word == MarkEepr) tracked_stage = STAGE_EEPR;
          else if (word == MarkFlas) tracked_stage = STAGE_FLAS;
          else if (word == MarkSram) tracked_stage = STAGE_SRAM;
        end
        STAGE_EEPR: begin
          if (word == TailOmV) tracked_kind = KIND_EEPROM;
          tracked_stage = STAGE_IDLE;
        end
        STAGE_FLAS: begin
          if (word[23:0] == TailHV || word == TailH512) tracked_kind = KIND_FL64;
          else if (word == TailH1m) tracked_kind = KIND_FL128;
          tracked_stage = STAGE_IDLE;
        end
        default: begin
          if (word[15:0] == TailUV || word == TailUFV) tracked_kind = KIND_SRAM;
          tracked_stage = STAGE_IDLE;
        end
      endcase
    end
    rep.kind  = tracked_kind;
    rep.bytes = save_size_of(tracked_kind);
    rep.ones  = (tracked_kind == KIND_FL64) || (tracked_kind == KIND_FL128) ||
                (tracked_kind == KIND_SRAM);
    return rep;
  endfunction

  // Receiver: random stalls at the current rate, or a long hold-off when one is asked for.
  // The hold-off length is counted down here so the sender keeps running meanwhile.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Checker: every result beat taken by the receiver is matched with the oldest report.
  always @(posedge clk_i) begin
    kind_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (kind_reports_q.size() == 0) begin
        $error("Result beat with no report waiting: kind %0d bytes %0d ones %0b",
               save_kind_o, save_bytes_o, fill_with_ones_o);
        err_count++;
      end else begin
        want = kind_reports_q.pop_front();
        reports_checked++;
        if (want.kind <= KIND_EEPROM) kinds_seen[want.kind]++;
        if (save_kind_o !== want.kind) begin
          $error("save_kind mismatch: expected %0d, actual %0d", want.kind, save_kind_o);
          err_count++;
        end
        if (save_bytes_o !== want.bytes) begin
          $error("save_bytes mismatch: expected %0d, actual %0d", want.bytes, save_bytes_o);
          err_count++;
        end
        if (fill_with_ones_o !== want.ones) begin
          $error("fill_with_ones mismatch: expected %0b, actual %0b",
                 want.ones, fill_with_ones_o);
          err_count++;
        end
      end
    end
  end

  // Offers one input beat, with random idle cycles ahead of it, and waits for acceptance.
  // Valid stays high past acceptance; the next call or drain_reports decides its fate.
  task automatic push_word(input logic [WordW-1:0] word, input logic start);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    image_word_i     <= word;
    start_of_image_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    kind_reports_q.push_back(detect_kind(word, start));
    words_sent++;
  endtask

  // Stops offering, waits for every owed report, then idles so that any stray extra
  // beat from the two-stage pipeline would still be caught.
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (kind_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [WordW-1:0] pick_marker();
    case ($urandom_range(2))
      0:       return MarkEepr;
      1:       return MarkFlas;
      default: return MarkSram;
    endcase
  endfunction

  // Any of the follow-up patterns, with random filler above the short ones.
  function automatic logic [WordW-1:0] pick_tail();
    logic [WordW-1:0] fill;
    fill = $urandom;
    case ($urandom_range(5))
      0:       return TailOmV;
      1:       return {fill[7:0], TailHV};
      2:       return TailH512;
      3:       return TailH1m;
      4:       return {fill[15:0], TailUV};
      default: return TailUFV;
    endcase
  endfunction

  // Directed words: every marker with every accepted follow-up, the stickiness of a
  // found kind, the follow-up that is itself a marker, near misses and extreme words.
  task automatic test_directed();
    push_word(32'h0000_0000, 1'b0);
    push_word(MarkEepr, 1'b0);
    push_word(TailOmV, 1'b0);
    // Kind is already found, so this flash pair must not change it.
    push_word(MarkFlas, 1'b0);
    push_word(TailH1m, 1'b0);
    push_word(MarkFlas, 1'b1);
    push_word(TailH512, 1'b0);
    push_word(MarkFlas, 1'b1);
    push_word({8'hA5, TailHV}, 1'b0);
    push_word(MarkFlas, 1'b1);
    push_word(TailH1m, 1'b0);
    push_word(MarkSram, 1'b1);
    push_word(TailUFV, 1'b0);
    push_word(MarkSram, 1'b1);
    push_word({16'hFFFF, TailUV}, 1'b0);
    // A marker in the follow-up slot is consumed as a failed follow-up, not re-armed.
    push_word(MarkEepr, 1'b1);
    push_word(MarkEepr, 1'b0);
    push_word(TailOmV, 1'b0);
    push_word(MarkSram, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(MarkFlas, 1'b0);
    push_word(TailH1m ^ 32'h0000_0001, 1'b0);
    push_word(MarkFlas, 1'b0);
    push_word(32'h0056_5F49, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    drain_reports();
  endtask

  // Random image streams: mostly marker pairs with random content, plus cross pairs,
  // near misses, noise and new-image starts that cut a pair in half.
  task automatic test_random_stream(input int unsigned n_words);
    int unsigned      sent_at_start;
    logic             first_start;
    logic             second_start;
    logic [WordW-1:0] mark;
    int unsigned      noise_len;
    sent_at_start = words_sent;
    while (words_sent - sent_at_start < n_words) begin
      first_start  = ($urandom_range(99) < 35);
      second_start = ($urandom_range(99) < 5);
      mark         = pick_marker();
      case ($urandom_range(11))
        0: begin
          push_word(MarkEepr, first_start);
          push_word(TailOmV, second_start);
        end
        1: begin
          push_word(MarkFlas, first_start);
          push_word({8'($urandom_range(255)), TailHV}, second_start);
        end
        2: begin
          push_word(MarkFlas, first_start);
          push_word(TailH512, second_start);
        end
        3: begin
          push_word(MarkFlas, first_start);
          push_word(TailH1m, second_start);
        end
        4: begin
          push_word(MarkSram, first_start);
          push_word({16'($urandom_range(65535)), TailUV}, second_start);
        end
        5: begin
          push_word(MarkSram, first_start);
          push_word(TailUFV, second_start);
        end
        6: begin
          push_word(mark, first_start);
          push_word(pick_tail(), second_start);
        end
        7: begin
          push_word(mark, first_start);
          push_word(pick_tail() ^ (32'd1 << $urandom_range(31)), second_start);
        end
        8: begin
          push_word(mark, first_start);
          push_word(pick_marker(), second_start);
        end
        11: push_word(pick_tail(), first_start);
        default: begin
          noise_len = $urandom_range(1, 4);
          repeat (noise_len) push_word($urandom, first_start && ($urandom_range(1) == 0));
        end
      endcase
    end
    drain_reports();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so the
  // pipeline fills and the input side has to stall.
  task automatic test_fill_stall();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    @(posedge clk_i);
    hold_req = 200;
    repeat (30) push_word(pick_marker(), 1'b1);
    repeat (30) push_word($urandom, 1'($urandom_range(1)));
    drain_reports();
  endtask

  // Sender pauses mid-stream until every owed report has come, then picks up where it
  // left off with an armed stage still pending.
  task automatic test_pause_drain();
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    repeat (19) push_word($urandom, 1'b0);
    push_word(MarkFlas, 1'b1);
    drain_reports();
    push_word(TailH512, 1'b0);
    repeat (19) push_word(pick_tail(), $urandom_range(99) < 10);
    drain_reports();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    image_word_i     = '0;
    start_of_image_i = 1'b0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    hold_req         = 0;
    words_sent       = 0;
    reports_checked  = 0;
    err_count        = 0;
    foreach (kinds_seen[i]) kinds_seen[i] = 0;
    tracked_stage    = STAGE_IDLE;
    tracked_kind     = KIND_NONE;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();

    // Idling phases: none, sender idle, receiver stalling, then both at a light rate.
    src_idle_pct = 0;  sink_stall_pct = 0;
    test_random_stream(280);
    src_idle_pct = 66; sink_stall_pct = 0;
    test_random_stream(280);
    src_idle_pct = 0;  sink_stall_pct = 66;
    test_random_stream(280);
    src_idle_pct = 21; sink_stall_pct = 21;
    test_random_stream(280);

    test_fill_stall();
    test_pause_drain();

    $display("Sent %0d image words and checked %0d result beats.", words_sent,
             reports_checked);
    $display("Reports by kind: none %0d, flash64 %0d, flash128 %0d, sram %0d, eeprom %0d.",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4]);
    if (err_count == 0 && kind_reports_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
